### rtl/pmf_pkg.sv
package pmf_pkg;

  // Queue geometry
  localparam int QueueDepth   = 4;
  localparam int PayloadBytes = 64;

  localparam int SLOT_W = $clog2(QueueDepth);
  localparam int CNT_W  = $clog2(QueueDepth + 1);
  localparam int IDX_W  = $clog2(PayloadBytes);
  localparam int RAM_AW = SLOT_W + IDX_W;
  localparam int RAM_DEPTH = QueueDepth << IDX_W;

  // Word field widths
  localparam int KIND_W = 2;
  localparam int PORT_W = 16;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;

  // Command queue between front and back
  localparam int CmdqDepth = 2;
  localparam int CMDQ_PW   = $clog2(CmdqDepth);

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_RECV = 2'd2
  } kind_e;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // One queued job for the back end: a single result word or a packet stream
  typedef struct packed {
    logic              stream;
    logic              status;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] slot;
  } pmf_cmd_t;

  // Payload write from the front end
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } pmf_wr_t;

  // Result word in flight inside the back end
  typedef struct packed {
    logic              stream;
    logic              status;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  len;
    logic              last;
  } pmf_res_t;

endpackage

### rtl/pmf_if.sv
interface pmf_in_if;
  import pmf_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PORT_W-1:0] port_number;
  logic [LEN_W-1:0]  byte_count;
  logic [BYTE_W-1:0] payload_byte;

  modport source (output valid, kind, port_number, byte_count, payload_byte, input ready);
  modport sink   (input valid, kind, port_number, byte_count, payload_byte, output ready);
endinterface

interface pmf_out_if;
  import pmf_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [PORT_W-1:0] out_port;
  logic [LEN_W-1:0]  out_length;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, status, out_port, out_length, out_byte, last, input ready);
  modport sink   (input valid, status, out_port, out_length, out_byte, last, output ready);
endinterface

### rtl/pmf_ram.sv
module pmf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/pmf_front.sv
module pmf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pmf_in_if.sink                     in_i,
  input  logic                       q_full_i,
  input  logic                       slot_busy_i,
  output logic [pmf_pkg::SLOT_W-1:0] tail_slot_o,
  output logic                       cmd_push_o,
  output pmf_pkg::pmf_cmd_t          cmd_o,
  output pmf_pkg::pmf_wr_t           wr_o
);
  import pmf_pkg::*;

  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              load_active_q, load_active_d;
  logic [LEN_W-1:0]  load_pos_q, load_pos_d, load_len_q, load_len_d;
  logic [PORT_W-1:0] port_store_q [QueueDepth];
  logic [LEN_W-1:0]  len_store_q [QueueDepth];
  logic              hdr_we;
  logic              accept;
  logic [SLOT_W-1:0] head_nxt, tail_nxt;
  logic [LEN_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  head_len;

  assign in_i.ready  = !q_full_i && !slot_busy_i;
  assign accept      = in_i.valid && in_i.ready;
  assign cmd_push_o  = accept;
  assign tail_slot_o = tail_q;

  assign head_nxt = (head_q == SLOT_W'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == SLOT_W'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
  assign pos_inc  = load_pos_q + 1'b1;
  assign head_len = len_store_q[head_q];

  // Classify the word and work out the new queue state
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    load_active_d = load_active_q;
    load_pos_d    = load_pos_q;
    load_len_d    = load_len_q;
    hdr_we        = 1'b0;
    cmd_o         = '{stream: 1'b0, status: STATUS_REFUSED, port: '0, len: '0, slot: head_q};
    wr_o          = '{en: 1'b0, addr: {tail_q, load_pos_q[IDX_W-1:0]}, data: in_i.payload_byte};
    case (in_i.kind)
      KIND_HDR: begin
        load_active_d = 1'b0;
        load_pos_d    = '0;
        load_len_d    = '0;
        if (in_i.byte_count <= LEN_W'(PayloadBytes) && count_q < CNT_W'(QueueDepth)) begin
          hdr_we       = accept;
          cmd_o.status = STATUS_OK;
          if (in_i.byte_count == '0) begin
            // empty packet commits at once
            tail_d  = tail_nxt;
            count_d = count_q + 1'b1;
          end else begin
            load_active_d = 1'b1;
            load_len_d    = in_i.byte_count;
          end
        end
      end
      KIND_DATA: begin
        if (load_active_q && load_pos_q < load_len_q) begin
          wr_o.en      = accept;
          cmd_o.status = STATUS_OK;
          load_pos_d   = pos_inc;
          if (pos_inc == load_len_q) begin
            tail_d        = tail_nxt;
            count_d       = count_q + 1'b1;
            load_active_d = 1'b0;
            load_pos_d    = '0;
            load_len_d    = '0;
          end
        end
      end
      KIND_RECV: begin
        if (count_q != '0 && in_i.byte_count >= head_len) begin
          cmd_o.status = STATUS_OK;
          cmd_o.stream = (head_len != '0);
          cmd_o.port   = port_store_q[head_q];
          cmd_o.len    = head_len;
          head_d       = head_nxt;
          count_d      = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      load_active_q <= 1'b0;
      load_pos_q    <= '0;
      load_len_q    <= '0;
    end else if (accept) begin
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      load_active_q <= load_active_d;
      load_pos_q    <= load_pos_d;
      load_len_q    <= load_len_d;
    end
  end

  // Per-slot header store
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      port_store_q[tail_q] <= in_i.port_number;
      len_store_q[tail_q]  <= in_i.byte_count;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QueueDepth))
    else $error("packet count above queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_active_q |-> (load_pos_q < load_len_q && load_len_q != '0))
    else $error("open load past its length");

endmodule

### rtl/pmf_cmd_q.sv
module pmf_cmd_q (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  pmf_pkg::pmf_cmd_t          cmd_i,
  input  logic                       pop_i,
  output pmf_pkg::pmf_cmd_t          cmd_o,
  output logic                       valid_o,
  output logic                       full_o,
  input  logic [pmf_pkg::SLOT_W-1:0] chk_slot_i,
  output logic                       slot_busy_o
);
  import pmf_pkg::*;

  pmf_cmd_t           entry_q [CmdqDepth];
  logic [CmdqDepth-1:0] vld_q;
  logic [CMDQ_PW-1:0] wptr_q, rptr_q;

  assign full_o  = vld_q[wptr_q];
  assign valid_o = vld_q[rptr_q];
  assign cmd_o   = entry_q[rptr_q];

  // A queued stream still has to read its slot's bytes
  always_comb begin
    slot_busy_o = 1'b0;
    for (int i = 0; i < CmdqDepth; i++) begin
      if (vld_q[i] && entry_q[i].stream && entry_q[i].slot == chk_slot_i) begin
        slot_busy_o = 1'b1;
      end
    end
  end

  // Pointers and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == CMDQ_PW'(CmdqDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == CMDQ_PW'(CmdqDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      for (int i = 0; i < CmdqDepth; i++) begin
        if (push_i && wptr_q == CMDQ_PW'(i)) begin
          vld_q[i] <= 1'b1;
        end else if (pop_i && rptr_q == CMDQ_PW'(i)) begin
          vld_q[i] <= 1'b0;
        end
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full command queue");

endmodule

### rtl/pmf_back.sv
module pmf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pmf_pkg::pmf_cmd_t          cmd_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_pop_o,
  output logic                       ram_re_o,
  output logic [pmf_pkg::RAM_AW-1:0] ram_raddr_o,
  input  logic [pmf_pkg::BYTE_W-1:0] ram_rdata_i,
  pmf_out_if.source                  out_o
);
  import pmf_pkg::*;

  logic [LEN_W-1:0]  idx_q;
  logic              s1_valid_q;
  pmf_res_t          s1_q, s1_d;
  logic              out_valid_q;
  logic              out_status_q, out_last_q;
  logic [PORT_W-1:0] out_port_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_free, s1_adv, issue, elem_last;

  // Two-stage pipe: RAM read stage, then output register
  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_adv    = s1_valid_q && out_free;
  assign issue     = cmd_valid_i && (!s1_valid_q || s1_adv);
  assign elem_last = !cmd_i.stream || (idx_q == cmd_i.len - LEN_W'(1));

  assign cmd_pop_o   = issue && elem_last;
  assign ram_re_o    = issue && cmd_i.stream;
  assign ram_raddr_o = {cmd_i.slot, idx_q[IDX_W-1:0]};

  always_comb begin
    s1_d.stream = cmd_i.stream;
    s1_d.status = cmd_i.status;
    s1_d.port   = cmd_i.port;
    s1_d.len    = cmd_i.len;
    s1_d.last   = elem_last;
  end

  // Byte index within the current packet, and the pipe valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= elem_last ? '0 : idx_q + 1'b1;
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_status_q <= s1_q.status;
      out_port_q   <= s1_q.port;
      out_len_q    <= s1_q.len;
      out_last_q   <= s1_q.last;
      out_byte_q   <= s1_q.stream ? ram_rdata_i : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.out_port   = out_port_q;
  assign out_o.out_length = out_len_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.last       = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_q.stream) |-> s1_q.last)
    else $error("single-word result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && cmd_i.stream) |-> (cmd_i.len != '0 && idx_q < cmd_i.len))
    else $error("stream byte index out of range");

endmodule

### rtl/packet_mailbox_fifo_unit.sv
// Throughput: one input word per cycle while the command queue has room; a receive delivers
// its payload one byte per cycle while the output is ready, from the payload RAM read port,
// and a two-entry command queue decouples input from output. Input waits while a queued
// receive still has bytes to read from the tail slot.
// Reset: queue pointers, packet count, load state and pipe valids clear; the payload
// RAM and the per-slot header store hold no reset value and need no clearing pass.
module packet_mailbox_fifo_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmf_in_if.sink    in_i,
  pmf_out_if.source out_o
);
  import pmf_pkg::*;

  pmf_cmd_t          push_cmd, head_cmd;
  pmf_wr_t           wr;
  logic              cmd_push, cmd_pop, q_valid, q_full, slot_busy;
  logic [SLOT_W-1:0] tail_slot;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Front end: accept and classify, update queue state, write payload
  pmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .slot_busy_i (slot_busy),
    .tail_slot_o (tail_slot),
    .cmd_push_o  (cmd_push),
    .cmd_o       (push_cmd),
    .wr_o        (wr)
  );

  // Command queue between the two sides
  pmf_cmd_q u_cmd_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .cmd_i       (push_cmd),
    .pop_i       (cmd_pop),
    .cmd_o       (head_cmd),
    .valid_o     (q_valid),
    .full_o      (q_full),
    .chk_slot_i  (tail_slot),
    .slot_busy_o (slot_busy)
  );

  // Payload store
  pmf_ram #(
    .Width (BYTE_W),
    .Depth (RAM_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back end: produce result words
  pmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (cmd_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

endmodule

### tb/sv/packet_mailbox_fifo_unit_tb.sv
module packet_mailbox_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmf_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 12;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int IdlePercent = 21;
  localparam int PrintCap    = 100;

  // Kind code outside the defined set; the block must refuse it
  localparam logic [KIND_W-1:0] KindReserved = 2'd3;

  typedef struct packed {
    logic              status;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic              last;
  } reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pmf_in_if  in_if ();
  pmf_out_if out_if ();

  packet_mailbox_fifo_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mailbox shadow state
  logic [BYTE_W-1:0] q_payload [QueueDepth * PayloadBytes];
  logic [PORT_W-1:0] q_port    [QueueDepth];
  logic [LEN_W-1:0]  q_len     [QueueDepth];
  int                q_head, q_tail, q_count;
  bit                ld_open;
  int                ld_pos, ld_len;

  reply_t reply_q [$];

  int          words_sent, results_checked, packets_delivered, refusals, mismatches;
  int unsigned cycle_count;
  int unsigned rx_hold;
  bit          tx_idles = 1'b1;
  bit          rx_idles = 1'b1;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("tb: mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s = 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
  endtask

  function automatic void push_reply(input logic st, input logic [PORT_W-1:0] p,
                                     input logic [LEN_W-1:0] l,
                                     input logic [BYTE_W-1:0] d, input logic lst);
    reply_t r;
    r = '{status: st, port: p, len: l, data: d, last: lst};
    reply_q.push_back(r);
    if (st == STATUS_REFUSED) refusals++;
  endfunction

  function automatic void commit_slot();
    q_tail  = (q_tail + 1) % QueueDepth;
    q_count++;
    ld_open = 1'b0;
    ld_pos  = 0;
    ld_len  = 0;
  endfunction

  // Work out the result words of one accepted word and update the shadow queue
  function automatic void predict_mailbox(input logic [KIND_W-1:0] kind,
                                          input logic [PORT_W-1:0] port,
                                          input logic [LEN_W-1:0] count,
                                          input logic [BYTE_W-1:0] data);
    int n;
    case (kind)
      KIND_HDR: begin
        // a header always drops an unfinished load
        ld_open = 1'b0;
        ld_pos  = 0;
        ld_len  = 0;
        if (count > PayloadBytes || q_count >= QueueDepth) begin
          push_reply(STATUS_REFUSED, '0, '0, '0, 1'b1);
        end else begin
          q_port[q_tail] = port;
          q_len[q_tail]  = count;
          ld_open = 1'b1;
          ld_len  = count;
          if (count == 0) commit_slot();
          push_reply(STATUS_OK, '0, '0, '0, 1'b1);
        end
      end
      KIND_DATA: begin
        if (!ld_open || ld_pos >= ld_len) begin
          push_reply(STATUS_REFUSED, '0, '0, '0, 1'b1);
        end else begin
          q_payload[q_tail * PayloadBytes + ld_pos] = data;
          ld_pos++;
          if (ld_pos == ld_len) commit_slot();
          push_reply(STATUS_OK, '0, '0, '0, 1'b1);
        end
      end
      KIND_RECV: begin
        if (q_count == 0 || count < q_len[q_head]) begin
          push_reply(STATUS_REFUSED, '0, '0, '0, 1'b1);
        end else begin
          n = q_len[q_head];
          if (n == 0) begin
            push_reply(STATUS_OK, q_port[q_head], '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++)
              push_reply(STATUS_OK, q_port[q_head], q_len[q_head],
                         q_payload[q_head * PayloadBytes + i], i == n - 1);
          end
          q_head = (q_head + 1) % QueueDepth;
          q_count--;
          packets_delivered++;
        end
      end
      default: push_reply(STATUS_REFUSED, '0, '0, '0, 1'b1);
    endcase
  endfunction

  // Offer one word, at times after a random gap; valid stays up for the next word
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PORT_W-1:0] port,
                           input logic [LEN_W-1:0] count, input logic [BYTE_W-1:0] data);
    if (tx_idles && $urandom_range(0, 99) < IdlePercent) begin
      in_if.valid        <= 1'b0;
      in_if.kind         <= KIND_W'($urandom);
      in_if.port_number  <= PORT_W'($urandom);
      in_if.byte_count   <= LEN_W'($urandom);
      in_if.payload_byte <= BYTE_W'($urandom);
      do @(posedge clk_i); while ($urandom_range(0, 99) < IdlePercent);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.port_number  <= port;
    in_if.byte_count   <= count;
    in_if.payload_byte <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
    predict_mailbox(kind, port, count, data);
  endtask

  // Sender goes quiet until every predicted word has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  // Header followed by nbytes random data words (nbytes < len leaves the load open)
  task automatic load_packet(input logic [PORT_W-1:0] port, input int len, input int nbytes);
    send_word(KIND_HDR, port, LEN_W'(len), BYTE_W'($urandom));
    for (int i = 0; i < nbytes; i++)
      send_word(KIND_DATA, PORT_W'($urandom), LEN_W'($urandom_range(0, 127)),
                BYTE_W'($urandom));
  endtask

  // Refusals of every kind but a full queue, zero-length packet, exact and short capacity
  task automatic test_refusals();
    send_word(KIND_RECV, 16'h0000, 7'd127, 8'h00);    // queue empty
    send_word(KIND_DATA, 16'hFFFF, 7'd127, 8'hFF);    // no open load
    send_word(KindReserved, 16'hFFFF, 7'd127, 8'hFF);
    send_word(KIND_HDR, 16'h1111, 7'd65, 8'h00);      // just over the limit
    send_word(KIND_HDR, 16'hFFFF, 7'd127, 8'hFF);
    send_word(KIND_HDR, 16'hFFFF, 7'd0, 8'h00);       // commits at once
    send_word(KIND_RECV, 16'hFFFF, 7'd0, 8'hFF);
    send_word(KIND_HDR, 16'h0000, 7'd2, 8'h00);
    send_word(KIND_DATA, 16'h0000, 7'd0, 8'hFF);
    send_word(KIND_DATA, 16'hFFFF, 7'd127, 8'h00);
    send_word(KIND_DATA, 16'h0000, 7'd0, 8'hA5);      // load already committed
    send_word(KIND_RECV, 16'h0000, 7'd1, 8'h00);      // capacity too small
    send_word(KIND_RECV, 16'h0000, 7'd2, 8'h00);      // exact fit
  endtask

  // A header drops an open load; a receive runs beside an open load
  task automatic test_load_interrupts();
    send_word(KIND_HDR, 16'h1234, 7'd3, 8'h00);
    send_word(KIND_DATA, 16'h0000, 7'd0, 8'h11);
    send_word(KIND_HDR, 16'hABCD, 7'd1, 8'h00);
    send_word(KIND_DATA, 16'h0000, 7'd0, 8'h22);
    send_word(KIND_HDR, 16'h5A5A, 7'd2, 8'h00);
    send_word(KIND_DATA, 16'h0000, 7'd0, 8'h33);
    send_word(KIND_RECV, 16'h0000, 7'd64, 8'h00);
    send_word(KIND_DATA, 16'h0000, 7'd0, 8'h44);
    send_word(KIND_RECV, 16'h0000, 7'd127, 8'h00);
  endtask

  // Fill every slot, then refuse a header, stray data and a short receive
  task automatic test_queue_full();
    for (int i = 0; i < QueueDepth; i++) load_packet(PORT_W'($urandom), 1, 1);
    send_word(KIND_HDR, PORT_W'($urandom), 7'd1, BYTE_W'($urandom));
    send_word(KIND_DATA, PORT_W'($urandom), 7'd1, BYTE_W'($urandom));
    send_word(KIND_RECV, PORT_W'($urandom), 7'd0, BYTE_W'($urandom));
    for (int i = 0; i < QueueDepth; i++)
      send_word(KIND_RECV, PORT_W'($urandom), 7'd1, BYTE_W'($urandom));
  endtask

  // Largest packets while the receiver holds off, so the input backs up
  task automatic test_holdoff();
    rx_hold = 400;
    for (int i = 0; i < QueueDepth; i++)
      load_packet(PORT_W'($urandom), PayloadBytes, PayloadBytes);
    send_word(KIND_HDR, PORT_W'($urandom), 7'd0, BYTE_W'($urandom));
    send_word(KIND_RECV, PORT_W'($urandom), LEN_W'(PayloadBytes - 1), BYTE_W'($urandom));
    for (int i = 0; i < QueueDepth; i++)
      send_word(KIND_RECV, PORT_W'($urandom), (i == 0) ? LEN_W'(PayloadBytes) : 7'd127,
                BYTE_W'($urandom));
  endtask

  // Mostly well-formed packets with random content, plus receives and noise
  task automatic test_random(input int target);
    int first, n, len, cut, sel, cap;
    first = words_sent;
    while (words_sent - first < target) begin
      n = words_sent - first;
      // one long stretch with both sides always willing
      tx_idles = (n < 40 || n > 150);
      rx_idles = tx_idles;
      sel = $urandom_range(0, 99);
      if (sel < 55 && q_count < QueueDepth) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) len = $urandom_range(0, 8);
        else if (sel < 95) len = $urandom_range(9, PayloadBytes - 1);
        else len = PayloadBytes;
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len) : len;
        load_packet(PORT_W'($urandom), len, cut);
      end else if (sel < 85) begin
        if (q_count != 0 && $urandom_range(0, 9) != 0)
          cap = $urandom_range(127, int'(q_len[q_head]));
        else
          cap = $urandom_range(0, 127);
        send_word(KIND_RECV, PORT_W'($urandom), LEN_W'(cap), BYTE_W'($urandom));
      end else begin
        send_word(KIND_W'($urandom_range(0, 3)), PORT_W'($urandom),
                  LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom));
      end
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
    tx_idles = 1'b1;
    rx_idles = 1'b1;
  endtask

  // Receiver: check each accepted word, then pick next ready
  initial begin : rx_side
    reply_t want;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word: status %0d port 0x%0h len %0d",
                                    out_if.status, out_if.out_port, out_if.out_length));
        end else begin
          want = reply_q.pop_front();
          check_field("status", 32'(out_if.status), 32'(want.status));
          check_field("out_port", 32'(out_if.out_port), 32'(want.port));
          check_field("out_length", 32'(out_if.out_length), 32'(want.len));
          check_field("out_byte", 32'(out_if.out_byte), 32'(want.data));
          check_field("last", 32'(out_if.last), 32'(want.last));
        end
        results_checked++;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(rx_idles && $urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_HDR;
    in_if.port_number  = '0;
    in_if.byte_count   = '0;
    in_if.payload_byte = '0;
    q_head  = 0;
    q_tail  = 0;
    q_count = 0;
    ld_open = 1'b0;
    ld_pos  = 0;
    ld_len  = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_refusals();
    wait_drained();
    test_load_interrupts();
    wait_drained();
    test_queue_full();
    wait_drained();
    test_holdoff();
    wait_drained();
    test_random(200);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d words sent, %0d result words checked, %0d packets delivered,",
             words_sent, results_checked, packets_delivered);
    $display("tb: %0d refusals, incl. full queue, oversize, short capacity, dropped loads",
             refusals);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
